/* rtl/afskc_pkg.sv */
// Shared types and constants for the AFSK correlator bit recovery core.
`default_nettype none

package afskc_pkg;

    // audio sample and table word widths
    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 16;
    localparam int PROD_W   = SAMPLE_W + WORD_W;

    // bit clock
    localparam int                  STEP_W           = 15;
    localparam int                  PHASE_W          = 16;
    localparam logic [STEP_W-1:0]   PHASE_STEP_RESET = 15'd3276;
    localparam logic [PHASE_W:0]    PHASE_HALF       = 17'h08000;

    // tone plan
    localparam longint unsigned AUDIO_FS   = 48000;
    localparam int unsigned     MARK_FREQ  = 1200;
    localparam int unsigned     SPACE_FREQ = 2200;

    // fixed-point constants for building the tone tables
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q15_MAX     = 64'd32767;

    // Taylor series divisors: sine (2k)(2k+1), cosine (2k-1)(2k)
    localparam longint unsigned S_DIV1 = 6;
    localparam longint unsigned S_DIV2 = 20;
    localparam longint unsigned S_DIV3 = 42;
    localparam longint unsigned S_DIV4 = 72;
    localparam longint unsigned S_DIV5 = 110;
    localparam longint unsigned C_DIV1 = 2;
    localparam longint unsigned C_DIV2 = 12;
    localparam longint unsigned C_DIV3 = 30;
    localparam longint unsigned C_DIV4 = 56;
    localparam longint unsigned C_DIV5 = 90;

    // sequencer to correlator controls
    typedef struct packed {
        logic clear;      // zero the accumulators
        logic tap_valid;  // window data and tap index are valid this cycle
        logic sq_en;      // square the four sums
        logic cmp_en;     // compare mark and space energy
    } corr_ctrl_t;

    // bit clock result for one correlation
    typedef struct packed {
        logic emit;       // clock wrapped, a bit is produced
        logic data_bit;   // NRZI-decoded bit
    } dpll_res_t;

endpackage

`default_nettype wire

/* rtl/afskc_win_mem.sv */
// Sample window memory: one write port, one registered read port.
`default_nettype none

module afskc_win_mem #(
    parameter int DEPTH = 40,
    parameter int AW    = 6
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [AW-1:0]                     waddr,
    input  wire logic signed [afskc_pkg::SAMPLE_W-1:0] wdata,
    input  wire logic [AW-1:0]                     raddr,
    output logic signed [afskc_pkg::SAMPLE_W-1:0]  rdata
);

    logic signed [afskc_pkg::SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/afskc_corr.sv */
// Four-lane correlator: tone tables, multiply-accumulate, squaring, tone decision.
`default_nettype none

module afskc_corr #(
    parameter int CORR_LEN = 40,
    parameter int IW       = 6
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire afskc_pkg::corr_ctrl_t                 ctrl,
    input  wire logic [IW-1:0]                         tap_idx,
    input  wire logic signed [afskc_pkg::SAMPLE_W-1:0] win_data,
    output logic                                       tone
);

    localparam int AW  = afskc_pkg::PROD_W + $clog2(CORR_LEN);
    localparam int CW  = AW - 15;
    localparam int SW  = 2 * CW;
    localparam int EW  = SW + 1;
    localparam int WW  = afskc_pkg::WORD_W;
    localparam int PW  = afskc_pkg::PROD_W;

    typedef logic [CORR_LEN-1:0][WW-1:0] tab_vec_t;

    function automatic longint unsigned q15_mag(input longint unsigned mag_q30);
        longint unsigned r;
        r = (mag_q30 + (64'd1 << 14)) >> 15;
        if (r > afskc_pkg::Q15_MAX)
        begin
            r = afskc_pkg::Q15_MAX;
        end
        return r;
    endfunction

    function automatic logic [WW-1:0] signed_word(input longint unsigned mag_q30,
                                                   input bit neg);
        logic [WW-1:0] w;
        w = WW'(q15_mag(mag_q30));
        return neg ? (~w + 1'b1) : w;
    endfunction

    // Q15 cos or sin of 2*pi*freq*idx/AUDIO_FS, series evaluated per quadrant
    function automatic logic [WW-1:0] tab_word(input longint unsigned freq,
                                                input longint unsigned idx,
                                                input bit sine);
        longint unsigned p;
        longint unsigned p4;
        longint unsigned quad;
        longint unsigned rem;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned s;
        longint unsigned c;
        longint unsigned ts;
        longint unsigned tc;
        logic [WW-1:0]   sw;
        logic [WW-1:0]   cw;
        p    = (freq * idx) % afskc_pkg::AUDIO_FS;
        p4   = p * 4;
        quad = (p4 / afskc_pkg::AUDIO_FS) & 64'd3;
        rem  = p4 - (p4 / afskc_pkg::AUDIO_FS) * afskc_pkg::AUDIO_FS;
        x    = rem * afskc_pkg::HALF_PI_Q30 / afskc_pkg::AUDIO_FS;
        x2   = (x * x) >> 30;
        s    = x;
        c    = afskc_pkg::Q30_ONE;
        ts   = x;
        tc   = afskc_pkg::Q30_ONE;
        ts = ((ts * x2) >> 30) / afskc_pkg::S_DIV1;
        tc = ((tc * x2) >> 30) / afskc_pkg::C_DIV1;
        s  = (s > ts) ? s - ts : 64'd0;
        c  = (c > tc) ? c - tc : 64'd0;
        ts = ((ts * x2) >> 30) / afskc_pkg::S_DIV2;
        tc = ((tc * x2) >> 30) / afskc_pkg::C_DIV2;
        s  = s + ts;
        c  = c + tc;
        ts = ((ts * x2) >> 30) / afskc_pkg::S_DIV3;
        tc = ((tc * x2) >> 30) / afskc_pkg::C_DIV3;
        s  = (s > ts) ? s - ts : 64'd0;
        c  = (c > tc) ? c - tc : 64'd0;
        ts = ((ts * x2) >> 30) / afskc_pkg::S_DIV4;
        tc = ((tc * x2) >> 30) / afskc_pkg::C_DIV4;
        s  = s + ts;
        c  = c + tc;
        ts = ((ts * x2) >> 30) / afskc_pkg::S_DIV5;
        tc = ((tc * x2) >> 30) / afskc_pkg::C_DIV5;
        s  = (s > ts) ? s - ts : 64'd0;
        c  = (c > tc) ? c - tc : 64'd0;
        case (quad)
            64'd0:
            begin
                sw = signed_word(s, 1'b0);
                cw = signed_word(c, 1'b0);
            end
            64'd1:
            begin
                sw = signed_word(c, 1'b0);
                cw = signed_word(s, 1'b1);
            end
            64'd2:
            begin
                sw = signed_word(s, 1'b1);
                cw = signed_word(c, 1'b1);
            end
            default:
            begin
                sw = signed_word(c, 1'b1);
                cw = signed_word(s, 1'b0);
            end
        endcase
        return sine ? sw : cw;
    endfunction

    function automatic tab_vec_t build_tab(input longint unsigned freq, input bit sine);
        tab_vec_t t;
        for (int i = 0; i < CORR_LEN; i++)
        begin
            t[i] = tab_word(freq, longint'(i), sine);
        end
        return t;
    endfunction

    localparam tab_vec_t MARK_C_TAB  = build_tab(afskc_pkg::MARK_FREQ, 1'b0);
    localparam tab_vec_t MARK_S_TAB  = build_tab(afskc_pkg::MARK_FREQ, 1'b1);
    localparam tab_vec_t SPACE_C_TAB = build_tab(afskc_pkg::SPACE_FREQ, 1'b0);
    localparam tab_vec_t SPACE_S_TAB = build_tab(afskc_pkg::SPACE_FREQ, 1'b1);

    // lane order: mark cos, mark sin, space cos, space sin
    logic signed [WW-1:0] coef     [4];
    logic signed [PW-1:0] prod_reg [4];
    logic signed [AW-1:0] acc_reg  [4];
    logic signed [CW-1:0] corr_q   [4];
    logic        [SW-1:0] sq_reg   [4];
    logic                 prod_v_reg;
    logic        [EW-1:0] mark_e;
    logic        [EW-1:0] space_e;
    logic                 tone_reg;

    always_comb
    begin
        coef[0] = $signed(MARK_C_TAB[tap_idx]);
        coef[1] = $signed(MARK_S_TAB[tap_idx]);
        coef[2] = $signed(SPACE_C_TAB[tap_idx]);
        coef[3] = $signed(SPACE_S_TAB[tap_idx]);
        for (int l = 0; l < 4; l++)
        begin
            corr_q[l] = CW'(acc_reg[l] >>> 15);   // floor shift
        end
        mark_e  = EW'(sq_reg[0]) + EW'(sq_reg[1]);
        space_e = EW'(sq_reg[2]) + EW'(sq_reg[3]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctrl.tap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            if (ctrl.tap_valid)
            begin
                prod_reg[l] <= win_data * coef[l];
            end
            if (ctrl.clear)
            begin
                acc_reg[l] <= '0;
            end
            else if (prod_v_reg)
            begin
                acc_reg[l] <= acc_reg[l] + {{(AW-PW){prod_reg[l][PW-1]}}, prod_reg[l]};
            end
            if (ctrl.sq_en)
            begin
                sq_reg[l] <= SW'(corr_q[l] * corr_q[l]);
            end
        end
        if (ctrl.cmp_en)
        begin
            tone_reg <= (mark_e > space_e);
        end
    end

    assign tone = tone_reg;

endmodule

`default_nettype wire

/* rtl/afskc_dpll.sv */
// Phase accumulator bit clock with transition nudge and NRZI decode.
`default_nettype none

module afskc_dpll (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              tone,
    input  wire logic [afskc_pkg::STEP_W-1:0]      phase_step,
    output afskc_pkg::dpll_res_t                   res
);

    localparam int PW = afskc_pkg::PHASE_W;

    logic [1:0]    tone_hist_reg;
    logic [1:0]    tone_hist_next;
    logic [PW-1:0] bit_phase_reg;
    logic [PW:0]   nudged;
    logic [PW:0]   phase_sum;
    logic [PW:0]   thresh;
    logic [PW:0]   nudge;
    logic [1:0]    sampled_reg;
    logic [1:0]    sampled_next;

    always_comb
    begin
        tone_hist_next = {tone_hist_reg[0], tone};
        thresh         = afskc_pkg::PHASE_HALF - (PW+1)'(phase_step >> 1);
        nudge          = (PW+1)'(phase_step >> 3);
        nudged         = {1'b0, bit_phase_reg};
        if (tone_hist_next[1] ^ tone_hist_next[0])
        begin
            if (nudged < thresh)
            begin
                nudged = nudged + nudge;
            end
            else
            begin
                nudged = nudged - nudge;
            end
        end
        phase_sum     = nudged + (PW+1)'(phase_step);
        sampled_next  = {sampled_reg[0], tone_hist_next[0]};
        res.emit      = phase_sum[PW];
        res.data_bit  = ~(sampled_next[1] ^ sampled_next[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_hist_reg <= '0;
            bit_phase_reg <= '0;
            sampled_reg   <= '0;
        end
        else if (en)
        begin
            tone_hist_reg <= tone_hist_next;
            bit_phase_reg <= phase_sum[PW-1:0];
            if (phase_sum[PW])
            begin
                sampled_reg <= sampled_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/afsk_correlator_bit_recovery_core.sv */
// Top level of the AFSK correlator bit recovery core: sequencer, window pointers, output register.
`default_nettype none

//  channel   dir  handshake                     payload
//  -------   ---  ----------------------------  --------------------------
//  input     in   in_valid / in_stall (out)     sample     signed [15:0]
//  output    out  out_valid / out_stall (in)    data_bit   [0]
//  config    in   cfg_wr_en                     cfg_wr_data [14:0] phase_step
//
//  A sample that does not start a correlation is accepted without a stall. Every
//  DECIMATION-th sample starts one and holds in_stall high through the CORR_LEN
//  window reads on the one read port, the read and product registers, square,
//  compare and the bit clock update. rst_n clears control state and the bit
//  clock; the window reads as zero until filled (fill count). A stalled result
//  holds only the bit clock step back.

module afsk_correlator_bit_recovery_core #(
    parameter int CORR_LEN   = 40,
    parameter int DECIMATION = 2
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [afskc_pkg::SAMPLE_W-1:0] sample,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic                                       data_bit,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [afskc_pkg::STEP_W-1:0]          cfg_wr_data
);

    localparam int IW  = $clog2(CORR_LEN);              // window address / tap index
    localparam int FW  = $clog2(CORR_LEN + 1);          // fill count
    localparam int RCW = $clog2(CORR_LEN + 2);          // run counter
    localparam int DCW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_PLL  = 3'd4;

    logic [2:0]                        state_reg,   state_next;
    logic [IW-1:0]                     wr_ptr_reg,  wr_ptr_next;
    logic [IW-1:0]                     rd_addr_reg, rd_addr_next;
    logic [FW-1:0]                     fill_reg,    fill_next;
    logic [DCW-1:0]                    dec_reg,     dec_next;
    logic [RCW-1:0]                    run_cnt_reg, run_cnt_next;
    logic                              v1_reg,      v1_next;
    logic [IW-1:0]                     tap_d1_reg;
    logic [afskc_pkg::STEP_W-1:0]      phase_step_reg;
    logic                              out_valid_reg, out_valid_next;
    logic                              data_bit_reg;

    logic                              accept;
    logic                              issue;
    logic                              slot_free;
    logic                              dpll_en;
    logic                              tap_ok;
    logic [IW-1:0]                     wr_ptr_inc;
    logic signed [afskc_pkg::SAMPLE_W-1:0] rd_data;
    logic signed [afskc_pkg::SAMPLE_W-1:0] win_data;
    logic                              tone;
    afskc_pkg::corr_ctrl_t             corr_ctrl;
    afskc_pkg::dpll_res_t              dpll_res;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign issue     = (state_reg == ST_RUN) && (run_cnt_reg < RCW'(CORR_LEN));
    assign wr_ptr_inc = (wr_ptr_reg == IW'(CORR_LEN - 1)) ? '0 : wr_ptr_reg + 1'b1;

    // Tap i (0 = oldest) holds a written sample once fill + i reaches CORR_LEN.
    assign tap_ok   = ((FW+1)'(tap_d1_reg) + (FW+1)'(fill_reg)) >= (FW+1)'(CORR_LEN);
    assign win_data = tap_ok ? rd_data : '0;

    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_addr_next   = rd_addr_reg;
        fill_next      = fill_reg;
        dec_next       = dec_reg;
        run_cnt_next   = run_cnt_reg;
        v1_next        = issue;
        dpll_en        = 1'b0;
        corr_ctrl      = '0;
        corr_ctrl.tap_valid = v1_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    wr_ptr_next = wr_ptr_inc;
                    if (fill_reg != FW'(CORR_LEN))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (dec_reg == DCW'(DECIMATION - 1))
                    begin
                        dec_next       = '0;
                        state_next     = ST_RUN;
                        run_cnt_next   = '0;
                        rd_addr_next   = wr_ptr_inc;   // oldest entry after this write
                        corr_ctrl.clear = 1'b1;
                    end
                    else
                    begin
                        dec_next = dec_reg + 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                run_cnt_next = run_cnt_reg + 1'b1;
                if (issue)
                begin
                    rd_addr_next = (rd_addr_reg == IW'(CORR_LEN - 1)) ? '0
                                                                       : rd_addr_reg + 1'b1;
                end
                // last product lands in the accumulators at the end of this cycle
                if (run_cnt_reg == RCW'(CORR_LEN + 1))
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                corr_ctrl.sq_en = 1'b1;
                state_next      = ST_CMP;
            end
            ST_CMP:
            begin
                corr_ctrl.cmp_en = 1'b1;
                state_next       = ST_PLL;
            end
            ST_PLL:
            begin
                if (slot_free)
                begin
                    dpll_en    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (dpll_en && dpll_res.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wr_ptr_reg     <= '0;
            rd_addr_reg    <= '0;
            fill_reg       <= '0;
            dec_reg        <= '0;
            run_cnt_reg    <= '0;
            v1_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_step_reg <= afskc_pkg::PHASE_STEP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_addr_reg   <= rd_addr_next;
            fill_reg      <= fill_next;
            dec_reg       <= dec_next;
            run_cnt_reg   <= run_cnt_next;
            v1_reg        <= v1_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                phase_step_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tap_d1_reg <= run_cnt_reg[IW-1:0];
        if (dpll_en && dpll_res.emit)
        begin
            data_bit_reg <= dpll_res.data_bit;
        end
    end

    afskc_win_mem #(
        .DEPTH (CORR_LEN),
        .AW    (IW)
    ) u_win_mem (
        .clk   (clk),
        .we    (accept),
        .waddr (wr_ptr_reg),
        .wdata (sample),
        .raddr (rd_addr_reg),
        .rdata (rd_data)
    );

    afskc_corr #(
        .CORR_LEN (CORR_LEN),
        .IW       (IW)
    ) u_corr (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (corr_ctrl),
        .tap_idx  (tap_d1_reg),
        .win_data (win_data),
        .tone     (tone)
    );

    afskc_dpll u_dpll (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (dpll_en),
        .tone       (tone),
        .phase_step (phase_step_reg),
        .res        (dpll_res)
    );

    assign out_valid = out_valid_reg;
    assign data_bit  = data_bit_reg;

endmodule

`default_nettype wire

/* verif/tb_afsk_correlator_bit_recovery_core.sv */
// Self-checking testbench for the AFSK correlator bit recovery core.
`timescale 1ns / 100ps

module tb_afsk_correlator_bit_recovery_core;

    // Geometry of the instance under test; the bit-exact model below uses the same values.
    localparam int CORR_LEN   = 40;
    localparam int DECIMATION = 2;

    // Cycles to let a sample still inside the correlator finish, with margin.
    localparam int SETTLE_CYCLES = 2 * (CORR_LEN + 6) + 10;

    // Long receiver hold-off, long enough for the core to back up into in_stall.
    localparam int HOLD_CYCLES = 1500;

    // Hard stop: several times the slowest legal run.
    localparam int LIMIT_NS = 4_000_000;

    // Bit clock wraps at 2^16; baud accumulator of the tone generator wraps at
    // 2^17 because it advances every sample, not every correlation.
    localparam int unsigned PHASE_WRAP = 32'd1 << afskc_pkg::PHASE_W;
    localparam int unsigned BAUD_WRAP  = 32'd1 << (afskc_pkg::PHASE_W + 1);

    localparam int unsigned TONE_RATE = afskc_pkg::AUDIO_FS;

    // Index into the four correlator tables.
    typedef enum int {
        MARK_COS  = 0,
        MARK_SIN  = 1,
        SPACE_COS = 2,
        SPACE_SIN = 3
    } tone_tab_e;

    typedef struct packed {
        logic data_bit;
    } bit_result_t;

    // DUT connections
    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_stall;
    logic signed [afskc_pkg::SAMPLE_W-1:0] sample;
    logic                                  out_valid;
    logic                                  out_stall;
    logic                                  data_bit;
    logic                                  cfg_wr_en;
    logic [afskc_pkg::STEP_W-1:0]          cfg_wr_data;

    // Demodulator model state
    int                                    tone_tab [4][CORR_LEN];
    logic signed [afskc_pkg::SAMPLE_W-1:0] window [CORR_LEN];
    int unsigned                           dec_cnt;
    logic [1:0]                            tone_hist;    // bit0 = newest raw tone
    int unsigned                           clk_phase;    // 16-bit bit clock
    logic [1:0]                            slice_hist;   // bit0 = newest sliced tone
    logic [afskc_pkg::STEP_W-1:0]          step_reg;

    // Decoded bits predicted but not yet seen on the output
    bit_result_t                           pending_bits [$];

    // Run bookkeeping
    int                                    fail_count;
    int                                    items_sent;
    int                                    bits_predicted;
    int                                    bits_checked;
    int                                    steps_used;
    int                                    holds_done;
    bit                                    idle_en;
    bit                                    hold_req;
    int                                    hold_left;
    bit_result_t                           want;

    afsk_correlator_bit_recovery_core #(
        .CORR_LEN   (CORR_LEN),
        .DECIMATION (DECIMATION)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_bit    (data_bit),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tone table words, integer only: quadrant split, Q30 Taylor series to
    // the 11th order, round half up to Q15, saturate, then apply the sign.
    // ------------------------------------------------------------------
    function automatic int q15_word(input longint unsigned mag, input bit neg);
        longint unsigned r;
        begin
            r = (mag + (64'd1 << 14)) >> 15;
            if (r > afskc_pkg::Q15_MAX)
                r = afskc_pkg::Q15_MAX;
            return neg ? -int'(r) : int'(r);
        end
    endfunction

    // ph is freq*index; only ph mod the sample rate matters.
    function automatic void tone_word(input longint unsigned ph, output int cos_w,
                                      output int sin_w);
        longint unsigned p4, rem, x, x2, s_acc, c_acc, s_term, c_term, whole;
        int unsigned     quad;
        begin
            p4     = (ph % afskc_pkg::AUDIO_FS) * 64'd4;
            whole  = p4 / afskc_pkg::AUDIO_FS;
            quad   = int'(whole) & 3;
            rem    = p4 - whole * afskc_pkg::AUDIO_FS;
            x      = rem * afskc_pkg::HALF_PI_Q30 / afskc_pkg::AUDIO_FS;
            x2     = (x * x) >> 30;
            s_acc  = x;
            c_acc  = afskc_pkg::Q30_ONE;
            s_term = x;
            c_term = afskc_pkg::Q30_ONE;
            for (int k = 1; k <= 5; k++)
            begin
                s_term = ((s_term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                c_term = ((c_term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
                if (k % 2 == 1)
                begin
                    // terms never exceed the partial sum in range, clamp anyway
                    s_acc = (s_acc > s_term) ? s_acc - s_term : 64'd0;
                    c_acc = (c_acc > c_term) ? c_acc - c_term : 64'd0;
                end
                else
                begin
                    s_acc = s_acc + s_term;
                    c_acc = c_acc + c_term;
                end
            end
            case (quad)
                0:
                begin
                    sin_w = q15_word(s_acc, 1'b0);
                    cos_w = q15_word(c_acc, 1'b0);
                end
                1:
                begin
                    sin_w = q15_word(c_acc, 1'b0);
                    cos_w = q15_word(s_acc, 1'b1);
                end
                2:
                begin
                    sin_w = q15_word(s_acc, 1'b1);
                    cos_w = q15_word(c_acc, 1'b1);
                end
                default:
                begin
                    sin_w = q15_word(c_acc, 1'b1);
                    cos_w = q15_word(s_acc, 1'b0);
                end
            endcase
        end
    endfunction

    // I^2 + Q^2 of the window against one tone; each sum is floor-shifted by 15.
    function automatic longint tone_energy(input tone_tab_e cos_sel, input tone_tab_e sin_sel);
        longint acc_c, acc_s;
        begin
            acc_c = 0;
            acc_s = 0;
            for (int i = 0; i < CORR_LEN; i++)
            begin
                acc_c += longint'(window[i]) * longint'(tone_tab[cos_sel][i]);
                acc_s += longint'(window[i]) * longint'(tone_tab[sin_sel][i]);
            end
            acc_c = acc_c >>> 15;
            acc_s = acc_s >>> 15;
            return acc_c * acc_c + acc_s * acc_s;
        end
    endfunction

    // Advance the demodulator model by one accepted sample; a wrap of the bit
    // clock queues one decoded bit.
    function automatic void demod_sample(input logic signed [afskc_pkg::SAMPLE_W-1:0] s);
        longint      mark_e, space_e;
        int unsigned step_u;
        bit          tone;
        bit_result_t res;
        begin
            for (int i = 0; i < CORR_LEN - 1; i++)
                window[i] = window[i + 1];
            window[CORR_LEN - 1] = s;
            dec_cnt++;
            if (dec_cnt >= DECIMATION)
            begin
                dec_cnt = 0;
                mark_e  = tone_energy(MARK_COS, MARK_SIN);
                space_e = tone_energy(SPACE_COS, SPACE_SIN);
                tone    = (mark_e > space_e);
                tone_hist = {tone_hist[0], tone};
                step_u  = step_reg;
                // tone transition: pull the bit clock toward mid-bit
                if (tone_hist[1] != tone_hist[0])
                begin
                    if (clk_phase < int'(afskc_pkg::PHASE_HALF) - (step_u >> 1))
                        clk_phase += step_u >> 3;
                    else
                        clk_phase -= step_u >> 3;
                end
                clk_phase += step_u;
                if (clk_phase >= PHASE_WRAP)
                begin
                    clk_phase &= PHASE_WRAP - 1;
                    slice_hist = {slice_hist[0], tone_hist[0]};
                    // NRZI: no tone change between slices decodes as 1
                    res.data_bit = ~(slice_hist[1] ^ slice_hist[0]);
                    pending_bits.push_back(res);
                    bits_predicted++;
                end
            end
        end
    endfunction

    // One sample of a tone with the given phase (in sample-rate units),
    // amplitude and uniform noise, saturated to 16 bits.
    function automatic logic signed [afskc_pkg::SAMPLE_W-1:0] tone_sample(input int unsigned ph,
                                                                          input int amp,
                                                                          input int noise_max);
        int c_w, s_w, v;
        begin
            tone_word(longint'(ph), c_w, s_w);
            v = ((c_w * amp) >>> 15) + (int'($urandom_range(0, 2 * noise_max)) - noise_max);
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            return 16'(v);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: optional random idle, then offer the item and hold it until
    // accepted. in_valid is left high so back-to-back items never see a
    // low/high pair in one time step.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic signed [afskc_pkg::SAMPLE_W-1:0] s);
        begin
            if (idle_en && $urandom_range(0, 99) < 25)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (idle_en && $urandom_range(0, 99) < 25);
            end
            in_valid <= 1'b1;
            sample   <= s;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            demod_sample(s);
            items_sent++;
        end
    endtask

    task automatic wait_drain;
        begin
            while (pending_bits.size() != 0)
                @(posedge clk);
        end
    endtask

    // Register write, only with the core idle: no bits pending and any
    // correlation that yields no bit given time to finish.
    task automatic set_step(input logic [afskc_pkg::STEP_W-1:0] val);
        begin
            in_valid <= 1'b0;
            wait_drain();
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= val;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            step_reg = val;
            steps_used++;
        end
    endtask

    task automatic send_noise(input int n);
        begin
            repeat (n)
                send_sample(16'($urandom_range(0, 65535)));
        end
    endtask

    // AFSK burst with continuous tone phase. Well-formed bursts use mark and
    // space at the given baud; broken ones mix in odd tones and phase jumps.
    task automatic send_burst(input int nbits, input int unsigned baud_step,
                              input bit well_formed);
        int unsigned baud_acc, tone_ph, freq;
        int          amp, noise_max;
        begin
            baud_acc  = 0;
            tone_ph   = $urandom_range(0, TONE_RATE - 1);
            amp       = $urandom_range(2000, 32767);
            noise_max = $urandom_range(0, 3000);
            repeat (nbits)
            begin
                freq = $urandom_range(0, 1) ? afskc_pkg::MARK_FREQ : afskc_pkg::SPACE_FREQ;
                if (!well_formed && $urandom_range(0, 3) == 0)
                begin
                    freq = $urandom_range(300, 4800);
                    if ($urandom_range(0, 1))
                        tone_ph = $urandom_range(0, TONE_RATE - 1);
                end
                while (baud_acc < BAUD_WRAP)
                begin
                    send_sample(tone_sample(tone_ph, amp, noise_max));
                    tone_ph  = (tone_ph + freq) % TONE_RATE;
                    baud_acc += baud_step;
                end
                baud_acc -= BAUD_WRAP;
            end
        end
    endtask

    // Baud matched to the current bit clock, kept reasonable for tiny steps.
    function automatic int unsigned matched_baud;
        begin
            return (step_reg < 2048) ? int'(afskc_pkg::PHASE_STEP_RESET) : int'(step_reg);
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full-scale and bit-pattern samples at the reset step.
    task automatic test_sample_extremes;
        begin
            send_sample(16'sh7fff);
            send_sample(16'sh8000);
            send_sample(16'sh0000);
            send_sample(16'shffff);
            send_sample(16'sh0001);
            send_sample(16'sh5555);
            send_sample(16'shaaaa);
            send_sample(16'sh8000);
            send_sample(16'sh7fff);
            send_sample(16'sh0000);
        end
    endtask

    // Clean tones with the step left at its reset value, so the reset value is exercised.
    task automatic test_reset_rate;
        begin
            send_burst(12, afskc_pkg::PHASE_STEP_RESET, 1'b1);
        end
    endtask

    // Largest step: the clock wraps about every other correlation; square
    // waves force tone flips so both nudge directions come up.
    task automatic test_step_max;
        begin
            set_step(15'h7fff);
            repeat (2)
            begin
                send_sample(16'sh7fff);
                send_sample(16'sh7fff);
                send_sample(16'sh8000);
                send_sample(16'sh8000);
                send_sample(16'sh0000);
            end
        end
    endtask

    // Zero step: the bit clock never moves, no bit may appear.
    task automatic test_step_zero;
        begin
            set_step(15'h0000);
            send_sample(16'sh7fff);
            send_sample(16'sh8000);
            send_sample(16'sh1234);
            send_sample(16'shedcb);
            send_sample(16'sh0000);
        end
    endtask

    // A sweep of steps from the smallest up, tones at matching baud, then a broken burst at a random step.
    task automatic test_tone_bursts;
        begin
            set_step(15'd1);
            send_burst(2, afskc_pkg::PHASE_STEP_RESET, 1'b1);
            set_step(15'd2048);
            send_burst(6, matched_baud(), 1'b1);
            set_step(15'd8192);
            send_burst(10, matched_baud(), 1'b1);
            set_step(15'h7fff);
            send_burst(16, matched_baud(), 1'b1);
            set_step(15'($urandom_range(1024, 32767)));
            send_burst(8, matched_baud(), 1'b0);
        end
    endtask

    // Receiver holds off for a long stretch while samples keep coming; the
    // output register fills and the core must stall its input. Then the
    // sender pauses until every pending bit has drained and sends a second burst.
    task automatic test_backpressure;
        begin
            set_step(15'd16384);
            hold_req = 1'b1;
            send_burst(40, matched_baud(), 1'b1);
            in_valid <= 1'b0;
            wait_drain();
            @(posedge clk);
            send_burst(20, matched_baud(), 1'b1);
        end
    endtask

    // Bulk random traffic: mostly well-formed bursts, some broken bursts and
    // raw noise, over random step settings. Starts without any idling.
    task automatic test_random_traffic;
        int start_items, seg_end, r;
        begin
            start_items = items_sent;
            idle_en     = 1'b0;
            while ((items_sent - start_items) < 400)
            begin
                if (items_sent - start_items >= 150)
                    idle_en = 1'b1;
                r = $urandom_range(0, 9);
                if (r < 4)
                    set_step(afskc_pkg::PHASE_STEP_RESET);
                else if (r < 7)
                    set_step(15'($urandom_range(1024, 32767)));
                else if (r == 7)
                    set_step(15'h7fff);
                else if (r == 8)
                    set_step(15'($urandom_range(2048, 8192)));
                else
                    set_step(15'($urandom_range(1, 1023)));
                seg_end = items_sent + ((step_reg < 1024) ? 80 : $urandom_range(150, 400));
                while (items_sent < seg_end)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        send_burst($urandom_range(4, 16), matched_baud(), 1'b1);
                    else if (r < 85)
                        send_burst($urandom_range(1, 8), $urandom_range(1024, 32767), 1'b0);
                    else
                        send_noise($urandom_range(1, 20));
                end
            end
            idle_en = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, or a counted long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
                holds_done++;
            end
            else
                out_stall <= idle_en && ($urandom_range(0, 99) < 25);
        end
    end

    // Output check: every accepted item against the oldest pending bit.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bits.size() == 0)
            begin
                $error("data_bit: unexpected item, expected none, actual %0b", data_bit);
                fail_count++;
            end
            else
            begin
                want = pending_bits.pop_front();
                if (data_bit !== want.data_bit)
                begin
                    $error("data_bit: expected %0b, actual %0b", want.data_bit, data_bit);
                    fail_count++;
                end
                bits_checked++;
            end
        end
    end

    // Hard time limit
    initial
    begin
        #(LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample         = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        fail_count     = 0;
        items_sent     = 0;
        bits_predicted = 0;
        bits_checked   = 0;
        steps_used     = 0;
        holds_done     = 0;
        idle_en        = 1'b1;
        hold_req       = 1'b0;
        hold_left      = 0;

        // model reset and tone tables
        for (int i = 0; i < CORR_LEN; i++)
        begin
            window[i] = '0;
            tone_word(longint'(afskc_pkg::MARK_FREQ) * i, tone_tab[MARK_COS][i],
                      tone_tab[MARK_SIN][i]);
            tone_word(longint'(afskc_pkg::SPACE_FREQ) * i, tone_tab[SPACE_COS][i],
                      tone_tab[SPACE_SIN][i]);
        end
        dec_cnt    = 0;
        tone_hist  = '0;
        clk_phase  = 0;
        slice_hist = '0;
        step_reg   = afskc_pkg::PHASE_STEP_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sample_extremes();
        test_reset_rate();
        test_step_max();
        test_step_zero();
        test_tone_bursts();
        test_backpressure();
        test_random_traffic();

        in_valid <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d samples and %0d decoded bits over %0d step settings",
                 items_sent, bits_checked, steps_used + 1);
        $display("including %0d long receiver hold-offs and random idling on both sides",
                 holds_done);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
